[sv/iee_pkg.sv]
// package for the infix expression evaluator
// holds word types, operator and status codes and state enums; no dependencies
package iee_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_word_t;

  // classified token passed from front to back
  typedef enum logic [1:0] {
    TK_DIGIT = 2'd0,
    TK_OPER  = 2'd1,
    TK_SKIP  = 2'd2,
    TK_BAD   = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_MALFORM  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    op_code_t   op;
    logic       last;
  } token_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TOKEN,
    BK_REDUCE,
    BK_DIVIDE,
    BK_FINISH,
    BK_EMIT
  } back_state_t;

  localparam int OP_DEPTH = 2;

endpackage

[sv/infix_expression_evaluator.sv]
// top level of the infix expression evaluator
// depends on iee_pkg, iee_front, iee_back (and iee_divider below it)
//
// Usage: characters of an infix expression arrive as in words (character,
// last) on a valid/stall channel. Digits 0-9, + - * / are evaluated with the
// usual precedence, left to right; spaces and parentheses are skipped.
// On the word marked last, one out word (value, status) is produced.
// The back end takes a word, then processes it: an add, subtract or
// multiply is one reduction, a division runs on the bit-serial divider.
// An operator triggers at most two reductions. A last word then passes a
// check step, drains the remaining operators and reaches an emit step,
// which registers the out word. The back end takes no new word until the
// current one is through it.
// A two-entry queue between front and back keeps taking words while the
// back end reduces. Reset clears counts, queue and output valid.
// A stalled out word holds; the back end waits in its emit step.
module infix_expression_evaluator #(
  parameter int VALUE_STACK_DEPTH = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iee_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iee_pkg::out_word_t out_data
);
  import iee_pkg::*;

  token_t tok_data;
  logic   tok_valid, tok_pop;

  iee_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .tok_valid(tok_valid), .tok_pop(tok_pop), .tok_data(tok_data)
  );

  iee_back #(.VALUE_STACK_DEPTH(VALUE_STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .tok_valid(tok_valid), .tok_pop(tok_pop),
    .tok_data(tok_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[sv/iee_front.sv]
// front end: accepts characters, classifies them, feeds a two-entry token queue
// depends on iee_pkg
module iee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iee_pkg::in_word_t in_data,
  output logic              tok_valid,
  input  logic              tok_pop,
  output iee_pkg::token_t   tok_data
);
  import iee_pkg::*;

  token_t     q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  token_t     cls;
  logic       push;

  // character classification
  always_comb begin
    cls = '0;
    cls.last = in_data.last;
    cls.digit = in_data.character[3:0];
    cls.kind = TK_BAD;
    cls.op = OP_ADD;
    case (in_data.character)
      8'h20, 8'h28, 8'h29: cls.kind = TK_SKIP;
      8'h2B: begin cls.kind = TK_OPER; cls.op = OP_ADD; end
      8'h2D: begin cls.kind = TK_OPER; cls.op = OP_SUB; end
      8'h2A: begin cls.kind = TK_OPER; cls.op = OP_MUL; end
      8'h2F: begin cls.kind = TK_OPER; cls.op = OP_DIV; end
      default: begin
        if (in_data.character >= 8'h30 && in_data.character <= 8'h39) cls.kind = TK_DIGIT;
      end
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign tok_valid = (cnt_r != 2'd0);
  assign tok_data  = q_r[rd_r];

  // queue pointers
  always_comb begin
    rd_nxt  = rd_r ^ tok_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, tok_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
  end

endmodule

[sv/iee_divider.sv]
// iterative restoring divider on magnitudes, one quotient bit per cycle
// depends on nothing but its parameter
module iee_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, d_r;
  logic [W:0]    rem_r, rem_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  assign trial    = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
  assign done     = busy_r && (cnt_r == CW'(1));
  assign quotient = q_nxt;

  // one shift-subtract step
  always_comb begin
    q_nxt = {q_r[W-2:0], ~trial[W]};
    rem_nxt = trial[W] ? {rem_r[W-1:0], q_r[W-1]} : trial;
    cnt_nxt = cnt_r - CW'(1);
    busy_nxt = busy_r && (cnt_r != CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend; d_r <= divisor; rem_r <= '0; cnt_r <= CW'(W);
    end else if (busy_r) begin
      q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/iee_back.sv]
// back end: operator and value stacks, reductions, result register
// depends on iee_pkg and iee_divider
module iee_back #(
  parameter int VALUE_STACK_DEPTH = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  output logic               tok_pop,
  input  iee_pkg::token_t    tok_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iee_pkg::out_word_t out_data
);
  import iee_pkg::*;

  localparam int CW = $clog2(VALUE_STACK_DEPTH + 1);
  localparam int IW = $clog2(VALUE_STACK_DEPTH);
  localparam int W  = VALUE_WIDTH;

  logic [W-1:0]  vs_r [VALUE_STACK_DEPTH];
  op_code_t      os_r [OP_DEPTH];
  logic [CW-1:0] vc_r, vc_nxt;
  logic [1:0]    oc_r, oc_nxt;
  status_t       err_r, err_nxt;
  back_state_t   st_r, st_nxt;
  token_t        tk_r;
  logic          tk_load;
  logic          ov_r, ov_nxt;
  out_word_t     od_r, od_nxt;

  // operands a and b latched for the reduction
  logic [W-1:0]  a_r, b_r, res_nxt, mul_res;
  logic [W-1:0]  amag, bmag, quo;
  logic          neg_r, div_start, div_done;
  op_code_t      rop;
  logic          top_prec;
  logic          vs_we, os_we;
  logic [IW-1:0] vs_wa;
  logic [W-1:0]  vs_wd;
  logic [63:0]   ext;

  assign amag = a_r[W-1] ? W'(-a_r) : a_r;
  assign bmag = b_r[W-1] ? W'(-b_r) : b_r;
  // top of the operator stack sits at count minus one
  assign rop  = os_r[~oc_r[0]];
  assign top_prec = rop[1];
  assign mul_res = W'(a_r * b_r);
  assign ext = 64'($signed(vs_r[0]));

  iee_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(amag), .divisor(bmag), .done(div_done), .quotient(quo)
  );

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; vc_r <= '0; oc_r <= '0; err_r <= ST_OK; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; vc_r <= vc_nxt; oc_r <= oc_nxt; err_r <= err_nxt; ov_r <= ov_nxt;
    end
  end

  // next state, stack control and result formation
  always_comb begin
    st_nxt = st_r; vc_nxt = vc_r; oc_nxt = oc_r; err_nxt = err_r;
    ov_nxt = ov_r && out_stall; od_nxt = od_r;
    tok_pop = 1'b0; tk_load = 1'b0; div_start = 1'b0;
    vs_we = 1'b0; vs_wa = '0; vs_wd = '0; os_we = 1'b0;
    res_nxt = '0;
    unique case (st_r)
      BK_IDLE: begin
        if (tok_valid) begin
          tok_pop = 1'b1; tk_load = 1'b1; st_nxt = BK_TOKEN;
        end
      end
      BK_TOKEN: begin
        st_nxt = tk_r.last ? BK_FINISH : BK_IDLE;
        if (err_r == ST_OK) begin
          case (tk_r.kind)
            TK_SKIP: ;
            TK_DIGIT: begin
              if (vc_r != CW'(oc_r)) err_nxt = ST_MALFORM;
              else if (vc_r >= CW'(VALUE_STACK_DEPTH)) err_nxt = ST_OVERFLOW;
              else begin
                vs_we = 1'b1; vs_wa = vc_r[IW-1:0]; vs_wd = W'(tk_r.digit);
                vc_nxt = vc_r + CW'(1);
              end
            end
            TK_OPER: begin
              if (vc_r == CW'(oc_r)) err_nxt = ST_MALFORM;
              else if (oc_r != 2'd0 && top_prec >= tk_r.op[1]) begin
                st_nxt = BK_REDUCE;
              end else if (oc_r >= 2'(OP_DEPTH)) err_nxt = ST_OVERFLOW;
              else begin
                os_we = 1'b1; oc_nxt = oc_r + 2'd1;
              end
            end
            default: err_nxt = ST_MALFORM;
          endcase
        end
      end
      BK_REDUCE: begin
        // a_r/b_r were latched when entering; combine top two values
        if (vc_r < CW'(2) || oc_r == 2'd0) begin
          err_nxt = ST_MALFORM;
          st_nxt = tk_r.last ? BK_FINISH : BK_IDLE;
        end else if (rop == OP_DIV) begin
          if (b_r == '0) begin
            err_nxt = ST_DIV_ZERO;
            st_nxt = tk_r.last ? BK_FINISH : BK_IDLE;
          end else begin
            div_start = 1'b1; st_nxt = BK_DIVIDE;
          end
        end else begin
          case (rop)
            OP_ADD:  res_nxt = a_r + b_r;
            OP_SUB:  res_nxt = a_r - b_r;
            default: res_nxt = mul_res;
          endcase
          vs_we = 1'b1; vs_wa = IW'(vc_r - CW'(2)); vs_wd = res_nxt;
          vc_nxt = vc_r - CW'(1); oc_nxt = oc_r - 2'd1;
          st_nxt = BK_TOKEN;
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          vs_we = 1'b1; vs_wa = IW'(vc_r - CW'(2));
          vs_wd = neg_r ? W'(-quo) : quo;
          vc_nxt = vc_r - CW'(1); oc_nxt = oc_r - 2'd1;
          st_nxt = BK_TOKEN;
        end
      end
      BK_FINISH: begin
        // check shape, drain remaining operators, then check that one value is left
        if (err_r != ST_OK) st_nxt = BK_EMIT;
        else if (vc_r == CW'(oc_r)) begin
          err_nxt = ST_MALFORM; st_nxt = BK_EMIT;
        end else if (oc_r != 2'd0) st_nxt = BK_REDUCE;
        else begin
          if (vc_r != CW'(1)) err_nxt = ST_MALFORM;
          st_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.status = err_r;
          od_nxt.value = (err_r == ST_OK) ? ext[31:0] : '0;
          vc_nxt = '0; oc_nxt = '0; err_nxt = ST_OK;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // reduction after an operator returns to BK_TOKEN to retry; the last token
  // going to BK_FINISH must not redo the token, so mark it as a skip
  always_ff @(posedge clk) begin
    if (tk_load) tk_r <= tok_data;
    else if (st_r == BK_TOKEN && st_nxt == BK_FINISH) tk_r.kind <= TK_SKIP;
    else if (st_r == BK_FINISH && st_nxt == BK_REDUCE) tk_r.kind <= TK_SKIP;
    if (os_we) os_r[oc_r[0]] <= tk_r.op;
    if (vs_we) vs_r[vs_wa] <= vs_wd;
    od_r <= od_nxt;
    if (st_nxt == BK_REDUCE) begin
      a_r <= vs_r[IW'(vc_r - CW'(2))];
      b_r <= vs_r[IW'(vc_r - CW'(1))];
    end
    if (div_start) neg_r <= a_r[W-1] ^ b_r[W-1];
  end

endmodule

[sv/iee_checker.sv]
// port-level checker for the infix expression evaluator
// depends on iee_pkg; bound to infix_expression_evaluator
module iee_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input iee_pkg::out_word_t out_data
);
  import iee_pkg::*;

  // a stalled out word stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out word dropped");

  // error results carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == '0) else $error("nonzero value");

  // nothing out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");

  // input open right after reset
  a_in_rst: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("stall after reset");

endmodule

bind infix_expression_evaluator iee_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
